>>> rtl/lpt_pkg.sv
// ----------------------------------------------------------------------------
// lpt_pkg
// shared types and constants of the lru page tracker
// ----------------------------------------------------------------------------
`default_nettype none

package lpt_pkg;

    localparam int DEPTH     = 16;
    localparam int PAGE_BITS = 16;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = 5;
    localparam int CAP_W     = 5;
    localparam int PAGE_W    = 16;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [ADDR_W-1:0] ADDR_CAPACITY = 3'd0;
    localparam logic [CAP_W-1:0]  CAPACITY_RESET = 5'd16;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic match;
        logic last;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

>>> rtl/lpt_ctrl.sv
// ----------------------------------------------------------------------------
// lpt_ctrl
// sequencer: accepts a reference, steps the list scan, commits the update
// ----------------------------------------------------------------------------
`default_nettype none

module lpt_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire lpt_pkg::status_t status,
    output lpt_pkg::cmd_t         cmd
);
    import lpt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.match || status.last)
                begin
                    // hold the decision until the result register is free
                    if (!status.out_busy)
                    begin
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/lpt_datapath.sv
// ----------------------------------------------------------------------------
// lpt_datapath
// recency list shift chain, scan index, fill count and result register
// ----------------------------------------------------------------------------
`default_nettype none

module lpt_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire lpt_pkg::cmd_t                  cmd,
    output lpt_pkg::status_t                    status,
    input  wire logic [lpt_pkg::CAP_W-1:0]      capacity,
    input  wire logic [lpt_pkg::PAGE_W-1:0]     page,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                hit,
    output logic                                evicted_valid,
    output logic [lpt_pkg::PAGE_W-1:0]          evicted_page,
    output logic [lpt_pkg::CNT_W-1:0]           fill_count
);
    import lpt_pkg::*;

    logic [PAGE_BITS-1:0] entry_reg [DEPTH];
    logic [PAGE_BITS-1:0] page_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 out_valid_reg;
    logic                 hit_reg;
    logic                 ev_valid_reg;
    logic [PAGE_W-1:0]    ev_page_reg;
    logic [CNT_W-1:0]     fill_reg;

    logic [CAP_W-1:0]     eff_cap;
    logic [CNT_W-1:0]     idx_ext;
    logic [PAGE_BITS-1:0] cur_entry;
    logic                 match;
    logic                 full;
    logic [IDX_W-1:0]     pos;

    always_comb
    begin
        priority if (capacity == '0)
        begin
            eff_cap = CAP_W'(1);
        end
        else if (capacity > CAP_W'(DEPTH))
        begin
            eff_cap = CAP_W'(DEPTH);
        end
        else
        begin
            eff_cap = capacity;
        end
    end

    assign idx_ext   = CNT_W'(idx_reg);
    assign cur_entry = entry_reg[idx_reg];
    assign match     = (idx_ext < count_reg) && (cur_entry == page_reg);
    assign full      = (CAP_W'(count_reg) >= eff_cap);

    // hit moves the found entry, a full miss drops the tail, else the list grows
    always_comb
    begin
        if (match || full)
        begin
            pos = idx_reg;
        end
        else
        begin
            pos = IDX_W'(count_reg);
        end
    end

    assign status.match    = match;
    assign status.last     = (count_reg == '0) || (idx_ext + CNT_W'(1) == count_reg);
    assign status.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg <= page[PAGE_BITS-1:0];
        end
        if (cmd.commit)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (i == 0)
                begin
                    entry_reg[i] <= page_reg;
                end
                else if (IDX_W'(i) <= pos)
                begin
                    entry_reg[i] <= entry_reg[i-1];
                end
            end
            hit_reg      <= match;
            ev_valid_reg <= !match && full;
            ev_page_reg  <= (!match && full) ? PAGE_W'(cur_entry) : '0;
            fill_reg     <= (!match && !full) ? count_reg + CNT_W'(1) : count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.commit && !match && !full)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign fill_count    = fill_reg;

endmodule

`default_nettype wire

>>> rtl/lru_page_tracker.sv
// ----------------------------------------------------------------------------
// lru_page_tracker
// least recently used page tracker with apb capacity register
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   page
// out       output     out_valid / out_ready hit, evicted_valid, evicted_page,
//                                            fill_count
// cfg       apb        psel / penable        capacity at address 0
//
// one reference at a time; the list is scanned one entry per cycle
// a hit ends the scan at the matching entry, a miss at the last filled entry;
// an empty list ends it at once; the update then commits and the next accept follows
// the next reference is taken while a result waits on out
// a stalled out holds the following update until its result is taken
// reset clears the internal fill count and loads capacity 16; list entries and result payload stay unset
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_tracker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lpt_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [lpt_pkg::DATA_W-1:0]    pwdata,
    output logic [lpt_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [lpt_pkg::PAGE_W-1:0]    page,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               hit,
    output logic                               evicted_valid,
    output logic [lpt_pkg::PAGE_W-1:0]         evicted_page,
    output logic [lpt_pkg::CNT_W-1:0]          fill_count
);
    import lpt_pkg::*;

    logic [CAP_W-1:0] capacity_reg;
    cmd_t             cmd;
    status_t          status;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_CAPACITY))
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_CAPACITY) ? DATA_W'(capacity_reg) : '0;

    lpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lpt_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .capacity      (capacity_reg),
        .page          (page),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fill_count    (fill_count)
    );

endmodule

`default_nettype wire
